@@ hdl/kdtk_pkg.sv @@
package kdtk_pkg;

    localparam int MAX_NODES_DEF   = 16384;
    localparam int STACK_DEPTH_DEF = 96;
    localparam int TOP_K_DEF       = 8;
    localparam int FEAT_DIM        = 5;
    localparam int FEAT_W          = 16;
    localparam int LINK_W          = 15;
    localparam int AXIS_W          = 3;
    localparam int ERR_W           = 19;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 1;
    localparam int VISIT_W         = 17;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VISIT_LIMIT = 1'b1;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [15:0] VISIT_LIMIT_RST = 16'd32768;

    // one feature gap, absolute value
    function automatic logic [FEAT_W-1:0] abs_gap(input logic [FEAT_W-1:0] a,
                                                  input logic [FEAT_W-1:0] b);
        abs_gap = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ hdl/kdtk_topk.sv @@
// sorted top-k candidate list; one insert step per call, one shift per cycle
module kdtk_topk #(
    parameter int TOP_K  = kdtk_pkg::TOP_K_DEF,
    parameter int NODE_W = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          ins_valid,
    input  logic [NODE_W-1:0]             ins_node,
    input  logic [kdtk_pkg::ERR_W-1:0]    ins_err,
    output logic                          ins_busy,
    output logic [$clog2(TOP_K+1)-1:0]    count,
    output logic [kdtk_pkg::ERR_W-1:0]    worst_err,
    input  logic [((TOP_K > 1) ? $clog2(TOP_K) : 1)-1:0] rd_idx,
    output logic [NODE_W-1:0]             rd_node,
    output logic [kdtk_pkg::ERR_W-1:0]    rd_err
);
    import kdtk_pkg::*;

    localparam int PW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int CW = $clog2(TOP_K+1);

    logic [NODE_W-1:0] node_reg [TOP_K];
    logic [ERR_W-1:0]  err_reg  [TOP_K];
    logic [CW-1:0]     count_reg, count_next;
    logic              busy_reg, busy_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [NODE_W-1:0] new_node_reg;
    logic [ERR_W-1:0]  new_err_reg;
    logic [PW-1:0]     pos_m1;

    assign ins_busy  = busy_reg;
    assign count     = count_reg;
    assign worst_err = err_reg[TOP_K-1];
    assign rd_node   = node_reg[rd_idx[PW-1:0]];
    assign rd_err    = err_reg[rd_idx[PW-1:0]];
    assign pos_m1    = pos_reg - PW'(1);

    // control for the insertion walk
    always_comb
    begin
        count_next = count_reg;
        busy_next  = busy_reg;
        pos_next   = pos_reg;
        if (clear)
        begin
            count_next = '0;
            busy_next  = 1'b0;
        end
        else if (ins_valid && !busy_reg)
        begin
            if (count_reg < CW'(TOP_K))
            begin
                count_next = count_reg + CW'(1);
                pos_next   = PW'(count_reg);
                busy_next  = 1'b1;
            end
            else if (ins_err < err_reg[TOP_K-1])
            begin
                pos_next  = PW'(TOP_K-1);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (pos_reg != '0 && err_reg[pos_m1] > new_err_reg)
                pos_next = pos_m1;
            else
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            pos_reg   <= pos_next;
        end
    end

    // list data: shift one entry down, or drop the new word in place
    always_ff @(posedge clk)
    begin
        if (ins_valid && !busy_reg && !clear)
        begin
            new_node_reg <= ins_node;
            new_err_reg  <= ins_err;
        end
        if (busy_reg && !clear)
        begin
            if (pos_reg != '0 && err_reg[pos_m1] > new_err_reg)
            begin
                node_reg[pos_reg] <= node_reg[pos_m1];
                err_reg[pos_reg]  <= err_reg[pos_m1];
            end
            else
            begin
                node_reg[pos_reg] <= new_node_reg;
                err_reg[pos_reg]  <= new_err_reg;
            end
        end
    end

endmodule

@@ hdl/kd_tree_topk_l1_search.sv @@
// Sequential k-nearest search over a kd-tree of up to MAX_NODES 5-D nodes, L1
// distance. start is taken only while busy is low; a write word keeps busy high
// while its five features go to the feature store (one feature store write per
// cycle), and the next word is taken only after busy falls again. A query runs
// a setup step, pops links (one that names no valid node is dropped), and for
// each visited node does 5 feature reads through one memory port into one shared
// abs/accumulate unit, then up to TOP_K-1 shift steps for the sorted list; it
// ends with the final stack check and the result words, and with node_count at
// zero a query goes straight to the empty result word.
// Results come out one per cycle on out_strobe and cannot be stalled; a query
// always ends with a word marked last_result (a single cand_valid=0 word when
// nothing was found).
module kd_tree_topk_l1_search #(
    parameter int MAX_NODES   = kdtk_pkg::MAX_NODES_DEF,
    parameter int STACK_DEPTH = kdtk_pkg::STACK_DEPTH_DEF,
    parameter int TOP_K       = kdtk_pkg::TOP_K_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [kdtk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kdtk_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic                              req_type,
    input  logic [13:0]                       node_index,
    input  logic [15:0]                       feature_0,
    input  logic [15:0]                       feature_1,
    input  logic [15:0]                       feature_2,
    input  logic [15:0]                       feature_3,
    input  logic [15:0]                       feature_4,
    input  logic [2:0]                        split_axis,
    input  logic signed [14:0]                left_child,
    input  logic signed [14:0]                right_child,
    output logic                              out_strobe,
    output logic                              cand_valid,
    output logic [2:0]                        cand_rank,
    output logic [13:0]                       cand_node,
    output logic [18:0]                       cand_error,
    output logic                              last_result
);
    import kdtk_pkg::*;

    localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH+1);
    localparam int KW  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int KCW = $clog2(TOP_K+1);
    localparam int LKW = AXIS_W + 2*LINK_W;

    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_INIT, S_POP, S_FREQ, S_FACC, S_LINK, S_INS,
        S_WAIT, S_PUSHF, S_PUSHN, S_EMIT, S_EMPTY
    } state_t;

    state_t state_reg;

    // registers
    logic [14:0]        node_count_reg;
    logic [15:0]        visit_limit_reg;
    logic [FEAT_W-1:0]  q_reg [FEAT_DIM];
    logic [VISIT_W-1:0] visit_reg;
    logic [SPW-1:0]     sp_reg;
    logic [NW-1:0]      cur_reg;
    logic [2:0]         dim_reg;
    logic [2:0]         rdim_reg;
    logic               rd_pending_reg;
    logic [ERR_W-1:0]   acc_reg;
    logic [FEAT_W-1:0]  axis_feat_reg;
    logic [LKW-1:0]     link_reg;
    logic [LINK_W-1:0]  far_reg, near_reg;
    logic               far_ok_reg;
    logic [KW-1:0]      emit_idx_reg;
    logic [31:0]        bound_reg;

    // memories
    logic [FEAT_W-1:0]  feat_mem [MAX_NODES*FEAT_DIM];
    logic [LKW-1:0]     link_mem [MAX_NODES];
    logic [LINK_W-1:0]  stack_mem [STACK_DEPTH];
    logic [FEAT_W-1:0]  feat_rd_reg;
    logic [LKW-1:0]     link_rd_reg;
    logic [LINK_W-1:0]  stack_rd_reg;

    localparam int FAW = $clog2(MAX_NODES*FEAT_DIM);

    logic              feat_we;
    logic [FAW-1:0]    feat_addr;
    logic [FEAT_W-1:0] feat_wd;
    logic [2:0]        wdim_reg;
    logic [NW-1:0]     widx_reg;
    logic [FEAT_W-1:0] wfeat_reg [FEAT_DIM];

    // write word buffer
    always_ff @(posedge clk)
    begin
        if (start && !busy && req_type == REQ_WRITE)
        begin
            widx_reg     <= NW'(node_index);
            wfeat_reg[0] <= feature_0;
            wfeat_reg[1] <= feature_1;
            wfeat_reg[2] <= feature_2;
            wfeat_reg[3] <= feature_3;
            wfeat_reg[4] <= feature_4;
        end
    end

    logic write_ok;
    assign write_ok = (32'(node_index) < 32'(MAX_NODES));

    // feature memory port
    always_comb
    begin
        feat_we   = (state_reg == S_WRITE);
        feat_wd   = wfeat_reg[wdim_reg];
        if (state_reg == S_WRITE)
            feat_addr = FAW'(32'(widx_reg) * FEAT_DIM + 32'(wdim_reg));
        else
            feat_addr = FAW'(32'(cur_reg) * FEAT_DIM + 32'(dim_reg));
    end

    always_ff @(posedge clk)
    begin
        if (feat_we)
            feat_mem[feat_addr] <= feat_wd;
        feat_rd_reg <= feat_mem[feat_addr];
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy && req_type == REQ_WRITE && write_ok)
            link_mem[NW'(node_index)] <= {split_axis, left_child, right_child};
        link_rd_reg <= link_mem[cur_reg];
    end

    // stack port
    logic              stk_we;
    logic [SW-1:0]     stk_waddr;
    logic [LINK_W-1:0] stk_wd;
    logic [SW-1:0]     stk_raddr;
    assign stk_raddr = SW'(sp_reg - SPW'(1));

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_waddr] <= stk_wd;
        stack_rd_reg <= stack_mem[stk_raddr];
    end

    // candidate list
    logic              ins_valid, ins_busy;
    logic [KCW-1:0]    cnt;
    logic [ERR_W-1:0]  worst_err, rd_err;
    logic [NW-1:0]     rd_node;

    kdtk_topk #(.TOP_K(TOP_K), .NODE_W(NW)) u_topk (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (state_reg == S_INIT),
        .ins_valid (ins_valid),
        .ins_node  (cur_reg),
        .ins_err   (acc_reg),
        .ins_busy  (ins_busy),
        .count     (cnt),
        .worst_err (worst_err),
        .rd_idx    (emit_idx_reg),
        .rd_node   (rd_node),
        .rd_err    (rd_err)
    );
    assign ins_valid = (state_reg == S_INS);

    // derived
    logic [15:0] ncount_lim;
    assign ncount_lim = (32'(node_count_reg) > 32'(MAX_NODES)) ? 16'(MAX_NODES)
                                                              : 16'(node_count_reg);
    logic signed [LINK_W-1:0] pop_id;
    assign pop_id = stack_rd_reg;
    logic pop_ok;
    assign pop_ok = !pop_id[LINK_W-1] && (16'(pop_id) < ncount_lim);

    logic [2:0] ax_fix;
    assign ax_fix = (link_rd_reg[LKW-1 -: AXIS_W] >= 3'(FEAT_DIM))
                    ? 3'd0 : link_rd_reg[LKW-1 -: AXIS_W];

    logic             below;
    logic [FEAT_W-1:0] axis_gap;
    assign below    = q_reg[ax_fix] < axis_feat_reg;
    assign axis_gap = abs_gap(q_reg[ax_fix], axis_feat_reg);

    // pushes onto a full stack are dropped and never touch the memory
    logic stk_room;
    assign stk_room = (sp_reg < SPW'(STACK_DEPTH));

    assign busy = (state_reg != S_IDLE);
    assign stk_we    = (state_reg == S_INIT)
                       || (state_reg == S_PUSHF && far_ok_reg && stk_room)
                       || (state_reg == S_PUSHN && stk_room);
    assign stk_waddr = (state_reg == S_INIT) ? '0 : SW'(sp_reg);
    assign stk_wd    = (state_reg == S_INIT) ? '0
                     : (state_reg == S_PUSHF) ? far_reg : near_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            node_count_reg  <= '0;
            visit_limit_reg <= VISIT_LIMIT_RST;
            sp_reg          <= '0;
            visit_reg       <= '0;
            bound_reg       <= '1;
            out_strobe      <= 1'b0;
            cand_valid      <= 1'b0;
            cand_rank       <= '0;
            cand_node       <= '0;
            cand_error      <= '0;
            last_result     <= 1'b0;
            wdim_reg        <= '0;
            dim_reg         <= '0;
            rdim_reg        <= '0;
            rd_pending_reg  <= 1'b0;
            emit_idx_reg    <= '0;
            cur_reg         <= '0;
        end
        else
        begin
            out_strobe <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NODE_COUNT:  node_count_reg  <= cfg_data[14:0];
                    REG_VISIT_LIMIT: visit_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        q_reg[0] <= feature_0;
                        q_reg[1] <= feature_1;
                        q_reg[2] <= feature_2;
                        q_reg[3] <= feature_3;
                        q_reg[4] <= feature_4;
                        wdim_reg <= '0;
                        if (req_type == REQ_QUERY)
                            state_reg <= S_INIT;
                        else if (write_ok)
                            state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    wdim_reg <= wdim_reg + 3'd1;
                    if (wdim_reg == 3'(FEAT_DIM-1))
                        state_reg <= S_IDLE;
                end
                S_INIT:
                begin
                    bound_reg <= '1;
                    visit_reg <= '0;
                    if (ncount_lim == '0)
                    begin
                        sp_reg    <= '0;
                        state_reg <= S_EMPTY;
                    end
                    else
                    begin
                        sp_reg    <= SPW'(1);
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    // stack read address settles and any list insert finishes, then pop or emit
                    if (ins_busy)
                        state_reg <= S_WAIT;
                    else if (sp_reg == '0)
                        state_reg <= S_EMIT;
                    else if (visit_reg + VISIT_W'(1) > VISIT_W'(visit_limit_reg))
                        state_reg <= S_EMIT;
                    else
                    begin
                        if (cnt == KCW'(TOP_K))
                            bound_reg <= 32'(worst_err);
                        visit_reg <= visit_reg + VISIT_W'(1);
                        sp_reg    <= sp_reg - SPW'(1);
                        state_reg <= S_POP;
                    end
                end
                S_POP:
                begin
                    if (pop_ok)
                    begin
                        cur_reg        <= NW'(pop_id);
                        dim_reg        <= '0;
                        rdim_reg       <= '0;
                        rd_pending_reg <= 1'b0;
                        acc_reg        <= '0;
                        state_reg      <= S_FREQ;
                    end
                    else
                        state_reg <= S_WAIT;
                end
                S_FREQ:
                begin
                    // address for dim_reg presented; data next cycle
                    rdim_reg  <= dim_reg;
                    dim_reg   <= dim_reg + 3'd1;
                    state_reg <= S_FACC;
                end
                S_FACC:
                begin
                    acc_reg <= acc_reg + ERR_W'(abs_gap(q_reg[rdim_reg], feat_rd_reg));
                    if (rdim_reg == 3'(FEAT_DIM-1))
                        state_reg <= S_LINK;
                    else
                        state_reg <= S_FREQ;
                end
                S_LINK:
                begin
                    link_reg  <= link_rd_reg;
                    dim_reg   <= ax_fix;
                    state_reg <= S_INS;
                end
                S_INS:
                begin
                    // list insert kicked off; read axis feature
                    rdim_reg  <= 3'd7;
                    state_reg <= S_PUSHF;
                    rd_pending_reg <= 1'b1;
                end
                S_PUSHF:
                begin
                    if (rd_pending_reg)
                    begin
                        axis_feat_reg  <= feat_rd_reg;
                        rd_pending_reg <= 1'b0;
                        far_ok_reg     <= 1'b0;
                    end
                    else if (ins_busy)
                        state_reg <= S_PUSHF;
                    else if (rdim_reg == 3'd7)
                    begin
                        // list settled; bound update then decide push
                        rdim_reg <= 3'd0;
                        if (cnt == KCW'(TOP_K))
                            bound_reg <= 32'(worst_err);
                        near_reg <= below ? link_reg[2*LINK_W-1:LINK_W]
                                          : link_reg[LINK_W-1:0];
                        far_reg  <= below ? link_reg[LINK_W-1:0]
                                          : link_reg[2*LINK_W-1:LINK_W];
                        far_ok_reg <= 32'(axis_gap) <=
                            ((cnt == KCW'(TOP_K)) ? 32'(worst_err) : bound_reg);
                    end
                    else
                    begin
                        if (far_ok_reg && stk_room)
                            sp_reg <= sp_reg + SPW'(1);
                        state_reg <= S_PUSHN;
                    end
                end
                S_PUSHN:
                begin
                    if (stk_room)
                        sp_reg <= sp_reg + SPW'(1);
                    state_reg <= S_WAIT;
                end
                S_EMIT:
                begin
                    if (cnt == '0)
                        state_reg <= S_EMPTY;
                    else
                    begin
                        out_strobe   <= 1'b1;
                        cand_valid   <= 1'b1;
                        cand_rank    <= 3'(emit_idx_reg);
                        cand_node    <= 14'(rd_node);
                        cand_error   <= rd_err;
                        last_result  <= (KCW'(emit_idx_reg) + KCW'(1) == cnt);
                        emit_idx_reg <= emit_idx_reg + KW'(1);
                        if (KCW'(emit_idx_reg) + KCW'(1) == cnt)
                        begin
                            emit_idx_reg <= '0;
                            state_reg    <= S_IDLE;
                        end
                    end
                end
                S_EMPTY:
                begin
                    out_strobe  <= 1'b1;
                    cand_valid  <= 1'b0;
                    cand_rank   <= '0;
                    cand_node   <= '0;
                    cand_error  <= '0;
                    last_result <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kdtk_pkg::*;

    typedef struct packed {
        logic              req_type;
        logic [13:0]       node_index;
        logic [4:0][15:0]  feat;
        logic [2:0]        split_axis;
        logic [14:0]       left_child;
        logic [14:0]       right_child;
    } word_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  rank;
        logic [13:0] node;
        logic [18:0] err;
        logic        last;
    } cand_t;

    // tree image, register copy and the queue of ranked candidates still owed
    class topk_scoreboard;
        logic [4:0][15:0] feat_mem [16384];
        logic [2:0]       axis_mem [16384];
        logic [14:0]      left_mem [16384];
        logic [14:0]      right_mem [16384];
        int unsigned      node_cnt = 0;
        int unsigned      visit_lim = 32768;
        cand_t            owed_q[$];
        int               errors = 0;

        function void report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            if (idx == REG_NODE_COUNT)
                node_cnt = val[14:0];
            else
                visit_lim = val;
        endfunction

        function int unsigned absd(logic [15:0] a, logic [15:0] b);
            return (a >= b) ? a - b : b - a;
        endfunction

        // store a node or run the depth-first top-k walk
        function void note_word(word_t w);
            int unsigned lim, sp, cnt, visits, err, ax, pos, n;
            logic [14:0]  stk [96];
            int unsigned  cnode [8];
            int unsigned  cerr [8];
            longint unsigned bound;
            logic [14:0]  near_l, far_l;
            int           id;
            bit           below;
            cand_t        c;
            if (w.req_type == REQ_WRITE) begin
                feat_mem[w.node_index]  = w.feat;
                axis_mem[w.node_index]  = w.split_axis;
                left_mem[w.node_index]  = w.left_child;
                right_mem[w.node_index] = w.right_child;
                return;
            end
            lim = (node_cnt > 16384) ? 16384 : node_cnt;
            sp = 0;
            cnt = 0;
            visits = 0;
            bound = 64'hFFFF_FFFF;
            if (lim != 0) begin
                stk[0] = '0;
                sp = 1;
            end
            while (sp > 0) begin
                visits++;
                if (visits > visit_lim)
                    break;
                sp--;
                id = $signed(stk[sp]);
                if (id < 0 || id >= int'(lim))
                    continue;
                n = id;
                err = 0;
                for (int d = 0; d < 5; d++)
                    err += absd(w.feat[d], feat_mem[n][d]);
                // sorted insert, ties keep the earlier entry first
                if (cnt < 8 || err < cerr[7]) begin
                    if (cnt < 8) begin
                        pos = cnt;
                        cnt++;
                    end
                    else
                        pos = 7;
                    while (pos > 0 && cerr[pos-1] > err) begin
                        cerr[pos]  = cerr[pos-1];
                        cnode[pos] = cnode[pos-1];
                        pos--;
                    end
                    cerr[pos]  = err;
                    cnode[pos] = n;
                end
                if (cnt == 8)
                    bound = cerr[7];
                ax = axis_mem[n];
                if (ax >= 5)
                    ax = 0;
                below  = w.feat[ax] < feat_mem[n][ax];
                near_l = below ? left_mem[n] : right_mem[n];
                far_l  = below ? right_mem[n] : left_mem[n];
                if (absd(w.feat[ax], feat_mem[n][ax]) <= bound && sp < 96) begin
                    stk[sp] = far_l;
                    sp++;
                end
                if (sp < 96) begin
                    stk[sp] = near_l;
                    sp++;
                end
            end
            if (cnt == 0) begin
                c = '0;
                c.last = 1'b1;
                owed_q.push_back(c);
            end
            for (int k = 0; k < int'(cnt); k++) begin
                c.valid = 1'b1;
                c.rank  = 3'(k);
                c.node  = 14'(cnode[k]);
                c.err   = 19'(cerr[k]);
                c.last  = (k + 1 == int'(cnt));
                owed_q.push_back(c);
            end
        endfunction

        function void check(cand_t got);
            cand_t want;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected word node %0d", got.node));
                return;
            end
            want = owed_q.pop_front();
            if (got.valid !== want.valid)
                report($sformatf("cand_valid %b want %b", got.valid, want.valid));
            if (got.rank !== want.rank)
                report($sformatf("cand_rank %0d want %0d", got.rank, want.rank));
            if (got.node !== want.node)
                report($sformatf("cand_node %0d want %0d", got.node, want.node));
            if (got.err !== want.err)
                report($sformatf("cand_error %0d want %0d", got.err, want.err));
            if (got.last !== want.last)
                report($sformatf("last_result %b want %b", got.last, want.last));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 start;
    logic                 busy;
    logic                 req_type;
    logic [13:0]          node_index;
    logic [15:0]          feature_0, feature_1, feature_2, feature_3, feature_4;
    logic [2:0]           split_axis;
    logic signed [14:0]   left_child, right_child;
    logic                 out_strobe;
    logic                 cand_valid;
    logic [2:0]           cand_rank;
    logic [13:0]          cand_node;
    logic [18:0]          cand_error;
    logic                 last_result;

    topk_scoreboard sb = new();
    int             idle_pct = 0;

    kd_tree_topk_l1_search i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .node_index  (node_index),
        .feature_0   (feature_0),
        .feature_1   (feature_1),
        .feature_2   (feature_2),
        .feature_3   (feature_3),
        .feature_4   (feature_4),
        .split_axis  (split_axis),
        .left_child  (left_child),
        .right_child (right_child),
        .out_strobe  (out_strobe),
        .cand_valid  (cand_valid),
        .cand_rank   (cand_rank),
        .cand_node   (cand_node),
        .cand_error  (cand_error),
        .last_result (last_result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_strobe)
            sb.check({cand_valid, cand_rank, cand_node, cand_error, last_result});
    end

    // hand one word over and wait until it is taken
    task automatic send_word(word_t w);
        @(negedge clk);
        start       = 1'b1;
        req_type    = w.req_type;
        node_index  = w.node_index;
        feature_0   = w.feat[0];
        feature_1   = w.feat[1];
        feature_2   = w.feat[2];
        feature_3   = w.feat[3];
        feature_4   = w.feat[4];
        split_axis  = w.split_axis;
        left_child  = w.left_child;
        right_child = w.right_child;
        do
            @(posedge clk);
        while (busy);
        sb.note_word(w);
        if ($urandom_range(99) < idle_pct) begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // let every owed candidate arrive and the block go quiet
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (sb.owed_q.size() != 0 || busy)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [15:0] rand_feat();
        return $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 12));
    endfunction

    // a link that never names a valid node under the given count
    function automatic logic [14:0] dead_link(int nc);
        if (nc < 16384 && $urandom_range(1))
            return 15'($urandom_range(16383, nc));
        return 15'(-$urandom_range(1, 16384));
    endfunction

    function automatic word_t node_word(int idx, logic [4:0][15:0] f, logic [2:0] ax,
                                        logic [14:0] l, logic [14:0] r);
        word_t w;
        w.req_type    = REQ_WRITE;
        w.node_index  = 14'(idx);
        w.feat        = f;
        w.split_axis  = ax;
        w.left_child  = l;
        w.right_child = r;
        return w;
    endfunction

    function automatic word_t query_word(logic [4:0][15:0] f);
        word_t w;
        w = '0;
        w.req_type = REQ_QUERY;
        w.feat     = f;
        w.node_index = 14'($urandom);
        w.split_axis = 3'($urandom);
        return w;
    endfunction

    // heap-shaped tree over nodes 0..n-1
    task automatic build_tree(int n, int nc);
        logic [4:0][15:0] f;
        logic [14:0]      l, r;
        for (int i = 0; i < n; i++) begin
            for (int d = 0; d < 5; d++)
                f[d] = rand_feat();
            l = (2*i + 1 < n) ? 15'(2*i + 1) : dead_link(nc);
            r = (2*i + 2 < n) ? 15'(2*i + 2) : dead_link(nc);
            send_word(node_word(i, f, 3'($urandom_range(7)), l, r));
        end
    endtask

    task automatic random_query();
        logic [4:0][15:0] f;
        for (int d = 0; d < 5; d++)
            f[d] = rand_feat();
        send_word(query_word(f));
    endtask

    task automatic random_phase(int pct);
        int n, nc;
        logic [4:0][15:0] f;
        n = $urandom_range(3, 31);
        case ($urandom_range(2))
            0: nc = n;
            1: nc = $urandom_range(1, n);
            default: nc = n + $urandom_range(1, 50);
        endcase
        drain();
        write_reg(REG_NODE_COUNT, 16'(nc));
        write_reg(REG_VISIT_LIMIT, $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(2, 40)));
        idle_pct = pct;
        build_tree(n, nc);
        for (int q = 0; q < 15; q++) begin
            // occasional stray node with dead links
            if ($urandom_range(9) == 0) begin
                for (int d = 0; d < 5; d++)
                    f[d] = rand_feat();
                send_word(node_word($urandom_range(16383), f, 3'($urandom),
                                    dead_link(16384), dead_link(16384)));
            end
            random_query();
        end
    endtask

    initial
    begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        logic [4:0][15:0] f;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        req_type = REQ_WRITE;
        node_index = '0;
        feature_0 = '0;
        feature_1 = '0;
        feature_2 = '0;
        feature_3 = '0;
        feature_4 = '0;
        split_axis = '0;
        left_child = '0;
        right_child = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty tree after reset
        send_word(query_word('0));
        // top slot with all-ones features, never reached
        send_word(node_word(16383, {5{16'hFFFF}}, 3'd7, 15'h3FFF, 15'h7FFF));
        build_tree(7, 7);
        drain();
        write_reg(REG_NODE_COUNT, 16'd7);
        write_reg(REG_VISIT_LIMIT, 16'hFFFF);
        send_word(query_word('0));
        send_word(query_word({5{16'hFFFF}}));
        send_word(query_word({5{16'h8000}}));
        // zero and single visit limits
        drain();
        write_reg(REG_VISIT_LIMIT, 16'd0);
        send_word(query_word({5{16'd3}}));
        drain();
        write_reg(REG_VISIT_LIMIT, 16'd1);
        send_word(query_word({5{16'd3}}));
        // node count above the array size
        drain();
        write_reg(REG_NODE_COUNT, 16'h7FFF);
        write_reg(REG_VISIT_LIMIT, 16'hFFFF);
        build_tree(7, 16384);
        send_word(query_word({5{16'd5}}));
        drain();
        write_reg(REG_NODE_COUNT, 16'd0);
        send_word(query_word({5{16'd5}}));

        // long chain, equal features: stack fills and ties pile up
        drain();
        write_reg(REG_NODE_COUNT, 16'd105);
        for (int i = 0; i < 105; i++)
            send_word(node_word(i, {5{16'd100}}, 3'd0, 15'h7FFF,
                                (i < 104) ? 15'(i + 1) : 15'h7FFF));
        send_word(query_word({5{16'd100}}));
        send_word(query_word({5{16'd101}}));
        send_word(query_word({5{16'd99}}));

        random_phase(17);
        random_phase(71);
        random_phase(0);
        drain();

        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
